@@ rtl/core/fpr_pkg.sv @@
// Package for the binary64 remainder unit.
// Holds constants and the controller/datapath command and status types.
package fpr_pkg;

  localparam logic [63:0] F64_INF         = 64'h7FF0000000000000;
  localparam logic [63:0] F64_MIN_NORM    = 64'h0010000000000000;
  localparam logic [63:0] F64_DEFAULT_NAN = 64'hFFF8000000000000;
  localparam logic [63:0] F64_SIGN_MASK   = 64'h8000000000000000;
  localparam logic [63:0] F64_FRAC_MASK   = 64'h000FFFFFFFFFFFFF;
  localparam logic [63:0] F64_HIDDEN_BIT  = 64'h0010000000000000;
  localparam logic [63:0] F64_QUIET_BIT   = 64'h0008000000000000;
  localparam logic [63:0] F64_ABS_MASK    = 64'h7FFFFFFFFFFFFFFF;

  typedef struct packed {
    logic load;
    logic norm;
    logic first;
    logic step;
    logic fin;
    logic pack;
    logic done;
  } fpr_cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
    logic steps_zero;
    logic pack_done;
  } fpr_sts_t;

endpackage

@@ rtl/core/fpr_ctrl.sv @@
// Controller state machine for the binary64 remainder unit.
// Depends on fpr_pkg for the command and status types.
module fpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fpr_pkg::fpr_cmd_t cmd,
  input  fpr_pkg::fpr_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_PACK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.special) begin
          state_nxt = S_OUT;
        end else if (sts.norm_done) begin
          state_nxt = S_FIRST;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (sts.steps_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_PACK;
      end
      S_PACK: begin
        if (sts.pack_done) begin
          cmd.done = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.pack = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/fpr_dp.sv @@
// Datapath for the binary64 remainder unit: special cases, normalisation,
// one-bit-per-cycle reduction and serial packing. Depends on fpr_pkg.
module fpr_dp (
  input  logic              clk,
  input  logic [63:0]       in_x_bits,
  input  logic [63:0]       in_y_bits,
  input  fpr_pkg::fpr_cmd_t cmd,
  output fpr_pkg::fpr_sts_t sts,
  output logic [63:0]       out_result_bits,
  output logic              out_invalid_flag
);

  logic [63:0] x_r, res_r;
  logic        inv_r, special_r, flip_r, q_r;
  logic [52:0] mx_r, my_r;
  logic [53:0] r_r;
  logic [12:0] ex_r, ey_r;
  logic [11:0] cnt_r;
  logic [63:0] ax, ay;
  logic        xsn, ysn;
  logic [53:0] sh, sub;
  logic [53:0] r2;
  logic        spec_hit, spec_inv;
  logic [63:0] spec_res;
  logic [62:0] pack_mag;

  assign ax  = in_x_bits & fpr_pkg::F64_ABS_MASK;
  assign ay  = in_y_bits & fpr_pkg::F64_ABS_MASK;
  assign xsn = (ax > fpr_pkg::F64_INF) && !ax[51];
  assign ysn = (ay > fpr_pkg::F64_INF) && !ay[51];
  assign sh  = {r_r[52:0], 1'b0};
  assign sub = sh - {1'b0, my_r};
  assign r2  = {r_r[52:0], 1'b0};

  assign sts.special    = special_r;
  assign sts.norm_done  = mx_r[52] && my_r[52];
  assign sts.steps_zero = (cnt_r == '0);
  assign sts.pack_done  = (r_r == '0) || r_r[52] || ($signed(ey_r) <= 13'sd1);
  assign out_result_bits  = res_r;
  assign out_invalid_flag = inv_r;

  always_comb begin
    spec_hit = 1'b1;
    spec_inv = 1'b0;
    spec_res = in_x_bits;
    priority if (ay > fpr_pkg::F64_INF) begin
      spec_res = (ax > fpr_pkg::F64_INF) ? (in_x_bits | fpr_pkg::F64_QUIET_BIT)
                                         : (in_y_bits | fpr_pkg::F64_QUIET_BIT);
      spec_inv = xsn | ysn;
    end else if (ax > fpr_pkg::F64_INF) begin
      spec_res = in_x_bits | fpr_pkg::F64_QUIET_BIT;
      spec_inv = xsn;
    end else if (ax == fpr_pkg::F64_INF || ay == '0) begin
      spec_res = fpr_pkg::F64_DEFAULT_NAN;
      spec_inv = 1'b1;
    end else if (ay == fpr_pkg::F64_INF || ax == '0) begin
      spec_res = in_x_bits;
    end else begin
      spec_hit = 1'b0;
    end
  end

  always_comb begin
    priority if (r_r == '0) begin
      pack_mag = '0;
    end else if ($signed(ey_r) <= 13'sd0) begin
      pack_mag = 63'(r_r[52:0] >> 6'(13'sd1 - $signed(ey_r)));
    end else if (r_r[52]) begin
      pack_mag = {ey_r[10:0], r_r[51:0]};
    end else begin
      pack_mag = {10'd0, r_r[52:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_x_bits;
      inv_r     <= spec_inv;
      special_r <= spec_hit;
      res_r     <= spec_res;
      mx_r      <= {(ax[62:52] != '0), ax[51:0]};
      my_r      <= {(ay[62:52] != '0), ay[51:0]};
      ex_r      <= (ax[62:52] == '0) ? 13'd1 : {2'b00, ax[62:52]};
      ey_r      <= (ay[62:52] == '0) ? 13'd1 : {2'b00, ay[62:52]};
    end
    if (cmd.norm) begin
      if (!mx_r[52]) begin
        mx_r <= {mx_r[51:0], 1'b0};
        ex_r <= ex_r - 13'd1;
      end
      if (!my_r[52]) begin
        my_r <= {my_r[51:0], 1'b0};
        ey_r <= ey_r - 13'd1;
      end
    end
    if (cmd.first) begin
      // x exponent below y: one below starts one step early with quotient zero, further below returns x.
      if ($signed(ex_r) < $signed(ey_r)) begin
        if ($signed(ex_r) + 13'sd1 == $signed(ey_r)) begin
          r_r  <= {1'b0, mx_r};
          ey_r <= ey_r - 13'd1;
          my_r <= my_r;
          cnt_r <= '0;
          q_r  <= 1'b0;
          // Cleared mx_r marks this case; rounding then compares against the doubled divisor.
          mx_r <= '0;
        end else begin
          r_r   <= '0;
          cnt_r <= '0;
          q_r   <= 1'b0;
        end
        if ($signed(ex_r) + 13'sd1 != $signed(ey_r)) begin
          res_r   <= x_r;
          special_r <= 1'b1;
        end
      end else if ({1'b0, mx_r} >= {1'b0, my_r}) begin
        r_r   <= {1'b0, mx_r - my_r};
        q_r   <= 1'b1;
        cnt_r <= 12'(ex_r - ey_r);
      end else begin
        r_r   <= {1'b0, mx_r};
        q_r   <= 1'b0;
        cnt_r <= 12'(ex_r - ey_r);
      end
    end
    if (cmd.step) begin
      cnt_r <= cnt_r - 12'd1;
      if (!sub[53]) begin
        r_r <= sub;
        q_r <= 1'b1;
      end else begin
        r_r <= sh;
        q_r <= 1'b0;
      end
    end
    if (cmd.fin) begin
      if (mx_r == '0 && my_r[52] && r_r[52]) begin
        // x exponent one below y: remainder is in units of ey-1, divisor 2*My.
        if (r_r > {1'b0, my_r} || (r_r == {1'b0, my_r} && q_r)) begin
          r_r    <= {my_r, 1'b0} - r_r;
          flip_r <= 1'b1;
        end else begin
          r_r    <= r_r;
          flip_r <= 1'b0;
        end
      end else if (r2 > {1'b0, my_r} || (r2 == {1'b0, my_r} && q_r)) begin
        r_r    <= {1'b0, my_r} - r_r;
        flip_r <= 1'b1;
      end else begin
        flip_r <= 1'b0;
      end
    end
    if (cmd.pack) begin
      r_r  <= {r_r[52:0], 1'b0};
      ey_r <= ey_r - 13'd1;
    end
    if (cmd.done) begin
      if (!special_r) begin
        res_r <= {flip_r ^ x_r[63], pack_mag};
      end
      special_r <= 1'b1;
    end
  end

endmodule

@@ rtl/core/fp64_ieee_remainder_unit.sv @@
// Top level of the binary64 IEEE remainder unit.
// Joins fpr_ctrl and fpr_dp; depends on fpr_pkg.
//
//  Channel | Ports                                   | Direction
//  in      | in_valid, in_ready, in_x_bits, in_y_bits | into the block
//  out     | out_valid, out_ready, out_result_bits,   | out of the block
//          | out_invalid_flag                        |
//
// One transaction at a time. After acceptance the controller performs the
// normalisation shifts (up to 52), a set-up state, one reduction step per
// exponent step (up to 2097), a rounding state, then the packing shifts (up
// to 52) before the result is shown. Special operands go from normalisation
// straight to the result. Reset returns the controller to idle. A stalled
// result holds until taken; the next transaction is accepted from the cycle
// after it.
module fp64_ieee_remainder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_x_bits,
  input  logic [63:0] in_y_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_bits,
  output logic        out_invalid_flag
);

  fpr_pkg::fpr_cmd_t cmd;
  fpr_pkg::fpr_sts_t sts;

  fpr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  fpr_dp u_dp (
    .clk(clk), .in_x_bits(in_x_bits), .in_y_bits(in_y_bits), .cmd(cmd), .sts(sts),
    .out_result_bits(out_result_bits), .out_invalid_flag(out_invalid_flag)
  );

endmodule
